[rtl/drhm_pkg.sv]
// Package for the damage rectangle history merger.
// Holds the command and result word types, box helpers and code constants.
// Depends on nothing.
package drhm_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;
    localparam logic [8:0] ALIGN_STEP_RST = 9'd32;
    localparam int MAG_W = 17;

    localparam logic [2:0] FN_MERGE     = 3'd0;
    localparam logic [2:0] FN_MERGE_HIT = 3'd1;
    localparam logic [2:0] FN_ISECT     = 3'd2;
    localparam logic [2:0] FN_CLIP      = 3'd3;
    localparam logic [2:0] FN_END       = 3'd4;

    localparam logic [2:0] CFG_SURF_L = 3'd0;
    localparam logic [2:0] CFG_SURF_T = 3'd1;
    localparam logic [2:0] CFG_SURF_W = 3'd2;
    localparam logic [2:0] CFG_SURF_H = 3'd3;
    localparam logic [2:0] CFG_STEP   = 3'd4;

    typedef logic signed [19:0] crd_t;

    localparam crd_t CRD_MIN  = -20'sd32768;
    localparam crd_t CRD_MAX  = 20'sd32767;
    localparam crd_t SIZE_MAX = 20'sd65535;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
        logic [7:0]         buffer_age;
        logic               align_enable;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] region_left;
        logic signed [15:0] region_top;
        logic [15:0]        region_width;
        logic [15:0]        region_height;
        logic               region_nonempty;
        logic               merge_hit;
    } result_t;

    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic [15:0]        w;
        logic [15:0]        h;
    } box_t;

    function automatic crd_t box_r(box_t b);
        return crd_t'(b.l) + crd_t'({1'b0, b.w});
    endfunction

    function automatic crd_t box_b(box_t b);
        return crd_t'(b.t) + crd_t'({1'b0, b.h});
    endfunction

    function automatic logic box_empty(box_t b);
        return (b.w == 16'd0) || (b.h == 16'd0);
    endfunction

    function automatic crd_t cmin(crd_t a, crd_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic crd_t cmax(crd_t a, crd_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic box_t make_box(crd_t l, crd_t t, crd_t r, crd_t b);
        box_t o;
        crd_t cl;
        crd_t ct;
        crd_t dw;
        crd_t dh;
        o  = '0;
        cl = (l < CRD_MIN) ? CRD_MIN : ((l > CRD_MAX) ? CRD_MAX : l);
        ct = (t < CRD_MIN) ? CRD_MIN : ((t > CRD_MAX) ? CRD_MAX : t);
        dw = r - cl;
        dh = b - ct;
        if ((r > l) && (b > t))
        begin
            o.l = cl[15:0];
            o.t = ct[15:0];
            o.w = (dw > SIZE_MAX) ? 16'hFFFF : dw[15:0];
            o.h = (dh > SIZE_MAX) ? 16'hFFFF : dh[15:0];
        end
        return o;
    endfunction

    function automatic box_t join_box(box_t a, box_t b);
        if (box_empty(b))
        begin
            return a;
        end
        if (box_empty(a))
        begin
            return b;
        end
        return make_box(cmin(crd_t'(a.l), crd_t'(b.l)), cmin(crd_t'(a.t), crd_t'(b.t)),
                        cmax(box_r(a), box_r(b)), cmax(box_b(a), box_b(b)));
    endfunction

    function automatic logic box_overlap(box_t a, box_t b);
        if (box_empty(a) || box_empty(b))
        begin
            return 1'b0;
        end
        return (crd_t'(a.l) < box_r(b)) && (crd_t'(b.l) < box_r(a)) &&
               (crd_t'(a.t) < box_b(b)) && (crd_t'(b.t) < box_b(a));
    endfunction

endpackage

[rtl/damage_rect_history_merger.sv]
// Top level of the damage rectangle history merger.
// Frame box, history ring, alignment remainder unit and sequencer.
// Depends on drhm_pkg.

// Keeps the bounding box of the current frame's damage and a ring of past
// frame boxes. Merge, merge-if-overlap, intersect and clip words go from idle
// to the done state directly. An end-frame word pushes the frame box into the
// ring and then joins the newest n ring entries, n being at least one and at
// most HISTORY_DEPTH. Alignment of the frame box runs when align_enable is
// set and align_step is above one, and on an aligned frame after one without
// align_enable each ring entry is aligned as well; empty boxes are skipped.
// Alignment passes the left, top, right and bottom edges of a box in turn
// through a single bit-serial remainder unit. busy is high from the accepted
// start until done rises; done lasts one cycle, not held off by the receiver.
module damage_rect_history_merger #(
    parameter int HISTORY_DEPTH = drhm_pkg::HISTORY_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  drhm_pkg::cmd_t    cmd,
    output logic              done,
    output drhm_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import drhm_pkg::*;

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ALOAD, ST_DSET, ST_DIV, ST_AFIN, ST_ANEXT, ST_RD,
        ST_PUSH, ST_WAIT, ST_WALK, ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic signed [15:0] surf_l_reg, surf_t_reg;
    logic [14:0]        surf_w_reg, surf_h_reg;
    logic [8:0]         step_reg;
    box_t               frame_reg, frame_next;
    box_t               region_reg, region_next;
    logic               hit_reg, hit_next;
    cmd_t               cmd_reg, cmd_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               aligned_reg, aligned_next;
    logic               tgt_reg, tgt_next;
    logic [PTR_W-1:0]   idx_reg, idx_next;
    box_t               abox_reg, abox_next;
    logic [1:0]         crd_reg, crd_next;
    crd_t               x_reg, x_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [8:0]         rem_reg, rem_next;
    logic [4:0]         bcnt_reg, bcnt_next;
    crd_t               edge_reg [4];
    crd_t               edge_val;
    logic               edge_we;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;
    logic [HISTORY_DEPTH-1:0] vld_reg, vld_next;

    box_t               ring_mem [HISTORY_DEPTH];
    box_t               rd_box_reg;
    logic               rd_vld_reg;
    box_t               rd_box;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    box_t               mem_wdata;

    box_t               opb, sbox, ab;
    logic               op_ne;
    logic [9:0]         rem_sh;
    logic [8:0]         rem_fin, fm;
    logic [PTR_W-1:0]   head_inc;
    logic [CNT_W-1:0]   count_inc;
    box_t               reg0;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign rd_box = rd_vld_reg ? rd_box_reg : box_t'('0);

    always_comb
    begin
        opb   = '{l: cmd.rect_left, t: cmd.rect_top,
                  w: cmd.rect_width[15:0], h: cmd.rect_height[15:0]};
        op_ne = (cmd.rect_width > 16'sd0) && (cmd.rect_height > 16'sd0);
        sbox  = '{l: surf_l_reg, t: surf_t_reg, w: {1'b0, surf_w_reg}, h: {1'b0, surf_h_reg}};
        ab    = make_box(edge_reg[0], edge_reg[1], edge_reg[2], edge_reg[3]);

        rem_sh  = {rem_reg, mag_reg[MAG_W-1]};
        rem_fin = (rem_sh >= {1'b0, step_reg}) ? 9'(rem_sh - {1'b0, step_reg}) : rem_sh[8:0];
        if (!crd_reg[1])
        begin
            fm = (x_reg >= 20'sd0) ? rem_fin : ((rem_fin != 9'd0) ? 9'(step_reg - rem_fin) : 9'd0);
            edge_val = x_reg - crd_t'({1'b0, fm});
        end
        else
        begin
            fm = (x_reg <= 20'sd0) ? rem_fin : ((rem_fin != 9'd0) ? 9'(step_reg - rem_fin) : 9'd0);
            edge_val = x_reg + crd_t'({1'b0, fm});
        end

        head_inc  = (head_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        count_inc = (count_reg == CNT_W'(HISTORY_DEPTH)) ? count_reg : count_reg + 1'b1;
        reg0      = frame_reg;

        state_next   = state_reg;
        frame_next   = frame_reg;
        region_next  = region_reg;
        hit_next     = hit_reg;
        cmd_next     = cmd_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        aligned_next = aligned_reg;
        tgt_next     = tgt_reg;
        idx_next     = idx_reg;
        abox_next    = abox_reg;
        crd_next     = crd_reg;
        x_next       = x_reg;
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        bcnt_next    = bcnt_reg;
        edge_we      = 1'b0;
        done_next    = 1'b0;
        result_next  = result_reg;
        vld_next     = vld_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = ab;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    hit_next = 1'b0;
                    state_next = ST_DONE;
                    case (cmd.func)
                        FN_MERGE:
                        begin
                            if (op_ne)
                            begin
                                frame_next = join_box(frame_reg, opb);
                            end
                        end
                        FN_MERGE_HIT:
                        begin
                            if (op_ne && box_overlap(frame_reg, opb))
                            begin
                                frame_next = join_box(frame_reg, opb);
                                hit_next   = 1'b1;
                            end
                        end
                        FN_ISECT:
                        begin
                            if (op_ne && box_overlap(frame_reg, opb))
                            begin
                                frame_next = make_box(
                                    cmax(crd_t'(frame_reg.l), crd_t'(opb.l)),
                                    cmax(crd_t'(frame_reg.t), crd_t'(opb.t)),
                                    cmin(box_r(frame_reg), box_r(opb)),
                                    cmin(box_b(frame_reg), box_b(opb)));
                            end
                            else
                            begin
                                frame_next = '0;
                            end
                        end
                        FN_CLIP:
                        begin
                            frame_next = make_box(
                                cmax(cmax(crd_t'(frame_reg.l), 20'sd0), crd_t'(sbox.l)),
                                cmax(cmax(crd_t'(frame_reg.t), 20'sd0), crd_t'(sbox.t)),
                                cmin(box_r(frame_reg), box_r(sbox)),
                                cmin(box_b(frame_reg), box_b(sbox)));
                        end
                        FN_END:
                        begin
                            tgt_next   = 1'b0;
                            state_next = (cmd.align_enable && step_reg > 9'd1) ? ST_ALOAD : ST_PUSH;
                        end
                        default:
                        begin
                            frame_next = frame_reg;
                        end
                    endcase
                    region_next = frame_next;
                end
            end
            ST_ALOAD:
            begin
                abox_next = tgt_reg ? rd_box : frame_reg;
                crd_next  = 2'd0;
                state_next = box_empty(abox_next) ? ST_ANEXT : ST_DSET;
            end
            ST_DSET:
            begin
                case (crd_reg)
                    2'd0:    x_next = crd_t'(abox_reg.l);
                    2'd1:    x_next = crd_t'(abox_reg.t);
                    2'd2:    x_next = box_r(abox_reg);
                    default: x_next = box_b(abox_reg);
                endcase
                mag_next   = (x_next < 20'sd0) ? MAG_W'(-x_next) : MAG_W'(x_next);
                rem_next   = '0;
                bcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = rem_fin;
                mag_next  = {mag_reg[MAG_W-2:0], 1'b0};
                bcnt_next = bcnt_reg + 1'b1;
                if (bcnt_reg == 5'(MAG_W - 1))
                begin
                    edge_we = 1'b1;
                    crd_next = crd_reg + 1'b1;
                    state_next = (crd_reg == 2'd3) ? ST_AFIN : ST_DSET;
                end
            end
            ST_AFIN:
            begin
                if (tgt_reg)
                begin
                    mem_we = 1'b1;
                    vld_next[idx_reg] = 1'b1;
                end
                else
                begin
                    frame_next = ab;
                end
                state_next = ST_ANEXT;
            end
            ST_ANEXT:
            begin
                if (!tgt_reg)
                begin
                    if (!aligned_reg)
                    begin
                        tgt_next   = 1'b1;
                        idx_next   = '0;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
                else if (idx_reg == PTR_W'(HISTORY_DEPTH - 1))
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_ALOAD;
            end
            ST_PUSH:
            begin
                aligned_next = cmd_reg.align_enable;
                head_next    = head_inc;
                count_next   = count_inc;
                mem_we       = 1'b1;
                mem_waddr    = head_inc;
                mem_wdata    = frame_reg;
                vld_next[head_inc] = 1'b1;
                if (cmd_reg.buffer_age == 8'd0 ||
                    9'(cmd_reg.buffer_age) > 9'(count_inc))
                begin
                    reg0      = join_box(frame_reg, sbox);
                    left_next = count_inc;
                end
                else
                begin
                    left_next = CNT_W'(cmd_reg.buffer_age);
                end
                region_next = reg0;
                idx_next    = head_inc;
                frame_next  = '0;
                state_next  = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (left_reg != '0)
                begin
                    region_next = join_box(region_reg, rd_box);
                    left_next   = left_reg - 1'b1;
                    idx_next    = (idx_reg == '0) ? PTR_W'(HISTORY_DEPTH - 1) : idx_reg - 1'b1;
                end
                state_next = (left_reg > CNT_W'(1)) ? ST_WAIT : ST_DONE;
            end
            ST_DONE:
            begin
                done_next   = 1'b1;
                result_next = '{region_left: region_reg.l, region_top: region_reg.t,
                                region_width: region_reg.w, region_height: region_reg.h,
                                region_nonempty: !box_empty(region_reg),
                                merge_hit: hit_reg};
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_box_reg <= ring_mem[idx_reg];
        if (edge_we)
        begin
            edge_reg[crd_reg] <= edge_val;
        end
        abox_reg <= abox_next;
        x_reg    <= x_next;
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        cmd_reg  <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            surf_l_reg  <= '0;
            surf_t_reg  <= '0;
            surf_w_reg  <= '0;
            surf_h_reg  <= '0;
            step_reg    <= ALIGN_STEP_RST;
            frame_reg   <= '0;
            region_reg  <= '0;
            hit_reg     <= 1'b0;
            head_reg    <= PTR_W'(HISTORY_DEPTH - 1);
            count_reg   <= '0;
            left_reg    <= '0;
            aligned_reg <= 1'b0;
            tgt_reg     <= 1'b0;
            idx_reg     <= '0;
            crd_reg     <= '0;
            bcnt_reg    <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            frame_reg   <= frame_next;
            region_reg  <= region_next;
            hit_reg     <= hit_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            aligned_reg <= aligned_next;
            tgt_reg     <= tgt_next;
            idx_reg     <= idx_next;
            crd_reg     <= crd_next;
            bcnt_reg    <= bcnt_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
            vld_reg     <= vld_next;
            rd_vld_reg  <= vld_reg[idx_reg];
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SURF_L: surf_l_reg <= cfg_data;
                    CFG_SURF_T: surf_t_reg <= cfg_data;
                    CFG_SURF_W: surf_w_reg <= cfg_data[14:0];
                    CFG_SURF_H: surf_h_reg <= cfg_data[14:0];
                    CFG_STEP:   step_reg   <= cfg_data[8:0];
                    default:    step_reg   <= step_reg;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("ring count above depth");
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.region_nonempty) |->
        (result.region_width != 16'd0 && result.region_height != 16'd0))
        else $error("nonempty flag with zero size");
`endif

endmodule
